// ===== rtl/core/particle_physics_step_defines.svh =====
// Assertion macros for the particle step core.
// Used by particle_physics_step.sv; expects i_clk and i_rst_n in scope.
`ifndef PARTICLE_PHYSICS_STEP_DEFINES_SVH
`define PARTICLE_PHYSICS_STEP_DEFINES_SVH

// consequent in the cycle after the antecedent
`define PP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent in the same cycle
`define PP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pp_pkg.sv =====
// Shared constants, types and helper functions for the particle step core.
// No dependencies.
package pp_pkg;

    localparam int FRAC_BITS = 10;
    localparam int W         = 24;
    localparam int MW        = 17;
    localparam int CW        = 12;
    localparam int MFB       = 15;
    localparam int QS        = 16;
    localparam int FORCE_K   = 100;
    localparam int FORCE_W   = 7;
    localparam int QW        = FRAC_BITS + 6;
    localparam int ATT_PRE   = 2 * FRAC_BITS - QW;
    localparam int WALL_W    = CW + 1 + FRAC_BITS;
    localparam int DXW       = (WALL_W > W ? WALL_W : W) + 1;
    localparam int AW        = DXW - 1;
    localparam int DW        = 2 * AW + 1;
    localparam int NUMW      = AW + FORCE_W;
    localparam int PW        = (WALL_W > W ? WALL_W : W) + 1;
    localparam int MNW       = W + MFB;
    localparam int SUMW      = (PW > MNW + 1 ? PW : MNW + 1) + 1;
    localparam int SAT_W     = 48;
    localparam int PRW       = W + QS + 1;
    localparam int REG_IDX_W = 3;

    localparam logic [W-1:0]  GRAV       = W'(((5 << FRAC_BITS) + 50) / 100);
    localparam logic [QS:0]   DECAY_K    = 17'd65470;
    localparam logic [QS:0]   BOUNCE_K   = 17'd58982;
    localparam logic [QS:0]   BOUNCE_B_K = 17'd29491;
    localparam logic [DW-1:0] ATT_THR    = DW'(4) << (2 * FRAC_BITS);

    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_MOUSE_X  = 3'd0;
    localparam t_reg_idx REG_MOUSE_Y  = 3'd1;
    localparam t_reg_idx REG_ATTRACT  = 3'd2;
    localparam t_reg_idx REG_FRICTION = 3'd3;
    localparam t_reg_idx REG_LEFT     = 3'd4;
    localparam t_reg_idx REG_TOP      = 3'd5;
    localparam t_reg_idx REG_WIDTH    = 3'd6;
    localparam t_reg_idx REG_HEIGHT   = 3'd7;

    typedef struct packed {
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic signed [W-1:0] vx;
        logic signed [W-1:0] vy;
        logic [MW-1:0]       mass;
    } t_part;

    typedef struct packed {
        t_part          p;
        logic [DW-1:0]  d;
        logic [DW-1:0]  rx;
        logic [DW-1:0]  ry;
        logic [QW-1:0]  qx;
        logic [QW-1:0]  qy;
        logic           gate;
        logic           sx;
        logic           sy;
    } t_adiv;

    typedef struct packed {
        logic [MNW-1:0]       nx;
        logic [MNW-1:0]       ny;
        logic [MW-1:0]        rx;
        logic [MW-1:0]        ry;
        logic [MW-1:0]        m;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [W-1:0]  vx;
        logic signed [W-1:0]  vy;
    } t_mdiv;

    function automatic logic [W-1:0] abs_w(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [SAT_W-1:0] v);
        if (v[SAT_W-1] && !(&v[SAT_W-2:W-1])) begin
            return {1'b1, {(W-1){1'b0}}};
        end else if (!v[SAT_W-1] && (|v[SAT_W-2:W-1])) begin
            return {1'b0, {(W-1){1'b1}}};
        end
        return $signed(v[W-1:0]);
    endfunction

    // magnitude product rounded half away from zero, sign reapplied
    function automatic logic signed [W+2:0] rnd_q(input logic [PRW-1:0] p, input logic neg);
        logic [PRW:0] t;
        logic [W+1:0] r;
        t = {1'b0, p} + (PRW+1)'(1 << (QS - 1));
        r = t[PRW:QS];
        return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

endpackage

// ===== rtl/core/particle_physics_step.sv =====
// Particle step core: attraction, friction, gravity, wall bounce, position update.
// Depends on pp_pkg and particle_physics_step_defines.svh.
//
// channel | direction | handshake             | payload
// in      | input     | i_valid / o_ready     | i_pos_x i_pos_y i_vel_x i_vel_y i_mass
// out     | output    | o_valid / i_ready     | o_new_pos_x o_new_pos_y o_new_vel_x o_new_vel_y
// cfg     | input     | i_cfg_we              | i_cfg_idx i_cfg_data
//
// One word per cycle while the output is not stalled. The pipeline holds two
// bit-per-stage dividers (attraction and velocity over mass).
// Synchronous active-low reset clears the stage valid flags and loads the config registers with their defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
`include "particle_physics_step_defines.svh"

module particle_physics_step
    import pp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_pos_x,
    input  logic signed [W-1:0] i_pos_y,
    input  logic signed [W-1:0] i_vel_x,
    input  logic signed [W-1:0] i_vel_y,
    input  logic [MW-1:0]       i_mass,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [W-1:0] o_new_pos_x,
    output logic signed [W-1:0] o_new_pos_y,
    output logic signed [W-1:0] o_new_vel_x,
    output logic signed [W-1:0] o_new_vel_y,
    input  logic                i_cfg_we,
    input  t_reg_idx            i_cfg_idx,
    input  logic [CW-1:0]       i_cfg_data
);

    logic [CW-1:0] r_mouse_x, r_mouse_y, r_left, r_top, r_width, r_height;
    logic          r_attract, r_friction;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mouse_x  <= '0;
            r_mouse_y  <= '0;
            r_attract  <= 1'b0;
            r_friction <= 1'b1;
            r_left     <= '0;
            r_top      <= '0;
            r_width    <= CW'(1920);
            r_height   <= CW'(1080);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MOUSE_X:  r_mouse_x  <= i_cfg_data;
                REG_MOUSE_Y:  r_mouse_y  <= i_cfg_data;
                REG_ATTRACT:  r_attract  <= i_cfg_data[0];
                REG_FRICTION: r_friction <= i_cfg_data[0];
                REG_LEFT:     r_left     <= i_cfg_data;
                REG_TOP:      r_top      <= i_cfg_data;
                REG_WIDTH:    r_width    <= i_cfg_data;
                REG_HEIGHT:   r_height   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_a_vld, r_b_vld, r_c_vld, r_t_vld, r_f_vld, r_g_vld, r_h_vld, r_r_vld, r_s_vld;
    logic r_o_vld;
    logic [QW-1:0]  r_dv_vld;
    logic [MNW-1:0] r_md_vld;

    assign w_en    = !r_o_vld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
            r_dv_vld <= '0;
            r_t_vld  <= 1'b0;
            r_f_vld  <= 1'b0;
            r_g_vld  <= 1'b0;
            r_h_vld  <= 1'b0;
            r_r_vld  <= 1'b0;
            r_s_vld  <= 1'b0;
            r_md_vld <= '0;
            r_o_vld  <= 1'b0;
        end else if (w_en) begin
            r_a_vld  <= i_valid;
            r_b_vld  <= r_a_vld;
            r_c_vld  <= r_b_vld;
            r_dv_vld <= {r_dv_vld[QW-2:0], r_c_vld};
            r_t_vld  <= r_dv_vld[QW-1];
            r_f_vld  <= r_t_vld;
            r_g_vld  <= r_f_vld;
            r_h_vld  <= r_g_vld;
            r_r_vld  <= r_h_vld;
            r_s_vld  <= r_r_vld;
            r_md_vld <= {r_md_vld[MNW-2:0], r_s_vld};
            r_o_vld  <= r_md_vld[MNW-1];
        end
    end

    // offsets to the mouse point
    t_part                 r_a_p;
    logic signed [DXW-1:0] r_a_dx, r_a_dy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_p.px   <= i_pos_x;
            r_a_p.py   <= i_pos_y;
            r_a_p.vx   <= i_vel_x;
            r_a_p.vy   <= i_vel_y;
            r_a_p.mass <= i_mass;
            r_a_dx <= DXW'($signed({1'b0, r_mouse_x, {FRAC_BITS{1'b0}}})) - DXW'(i_pos_x);
            r_a_dy <= DXW'($signed({1'b0, r_mouse_y, {FRAC_BITS{1'b0}}})) - DXW'(i_pos_y);
        end
    end

    // squares and scaled numerators
    logic [AW-1:0]   w_ax, w_ay;
    t_part           r_b_p;
    logic [2*AW-1:0] r_b_sqx, r_b_sqy;
    logic [NUMW-1:0] r_b_numx, r_b_numy;
    logic            r_b_sx, r_b_sy;
    assign w_ax = r_a_dx[DXW-1] ? AW'(-r_a_dx) : AW'(r_a_dx);
    assign w_ay = r_a_dy[DXW-1] ? AW'(-r_a_dy) : AW'(r_a_dy);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_p    <= r_a_p;
            r_b_sqx  <= (2*AW)'(w_ax) * (2*AW)'(w_ax);
            r_b_sqy  <= (2*AW)'(w_ay) * (2*AW)'(w_ay);
            r_b_numx <= NUMW'(w_ax) * NUMW'(FORCE_K);
            r_b_numy <= NUMW'(w_ay) * NUMW'(FORCE_K);
            r_b_sx   <= r_a_dx[DXW-1];
            r_b_sy   <= r_a_dy[DXW-1];
        end
    end

    // distance squared, threshold, divider seed
    logic [DW-1:0] w_d;
    t_adiv         r_c;
    assign w_d = DW'(r_b_sqx) + DW'(r_b_sqy);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c.p    <= r_b_p;
            r_c.d    <= w_d;
            r_c.rx   <= DW'(r_b_numx) << ATT_PRE;
            r_c.ry   <= DW'(r_b_numy) << ATT_PRE;
            r_c.qx   <= '0;
            r_c.qy   <= '0;
            r_c.gate <= r_attract && (w_d > ATT_THR);
            r_c.sx   <= r_b_sx;
            r_c.sy   <= r_b_sy;
        end
    end

    // attraction divider, one quotient bit per stage
    t_adiv r_dv [QW];
    for (genvar k = 0; k < QW; k++) begin : g_adiv
        t_adiv       in_s, n_s;
        logic [DW:0] tx, ty;
        if (k == 0) begin : g_first
            assign in_s = r_c;
        end else begin : g_next
            assign in_s = r_dv[k-1];
        end
        always_comb begin
            n_s = in_s;
            tx  = {in_s.rx, 1'b0};
            ty  = {in_s.ry, 1'b0};
            if (tx >= {1'b0, in_s.d}) begin
                n_s.rx = DW'(tx - {1'b0, in_s.d});
                n_s.qx = {in_s.qx[QW-2:0], 1'b1};
            end else begin
                n_s.rx = DW'(tx);
                n_s.qx = {in_s.qx[QW-2:0], 1'b0};
            end
            if (ty >= {1'b0, in_s.d}) begin
                n_s.ry = DW'(ty - {1'b0, in_s.d});
                n_s.qy = {in_s.qy[QW-2:0], 1'b1};
            end else begin
                n_s.ry = DW'(ty);
                n_s.qy = {in_s.qy[QW-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[k] <= n_s;
            end
        end
    end

    // apply attraction
    t_adiv                 w_ad;
    logic signed [SAT_W-1:0] w_qx, w_qy;
    t_part                 r_t;
    assign w_ad = r_dv[QW-1];
    assign w_qx = SAT_W'($signed({1'b0, w_ad.qx}));
    assign w_qy = SAT_W'($signed({1'b0, w_ad.qy}));
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t.px   <= w_ad.p.px;
            r_t.py   <= w_ad.p.py;
            r_t.mass <= w_ad.p.mass;
            r_t.vx   <= sat_w(SAT_W'(w_ad.p.vx) + (w_ad.gate ? (w_ad.sx ? -w_qx : w_qx) : '0));
            r_t.vy   <= sat_w(SAT_W'(w_ad.p.vy) + (w_ad.gate ? (w_ad.sy ? -w_qy : w_qy) : '0));
        end
    end

    // friction product
    t_part          r_f;
    logic [PRW-1:0] r_f_prx, r_f_pry;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f     <= r_t;
            r_f_prx <= PRW'(abs_w(r_t.vx)) * PRW'(DECAY_K);
            r_f_pry <= PRW'(abs_w(r_t.vy)) * PRW'(DECAY_K);
        end
    end

    // friction round and select
    t_part r_g;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g.px   <= r_f.px;
            r_g.py   <= r_f.py;
            r_g.mass <= r_f.mass;
            r_g.vx   <= r_friction ? sat_w(SAT_W'(rnd_q(r_f_prx, r_f.vx[W-1]))) : r_f.vx;
            r_g.vy   <= r_friction ? sat_w(SAT_W'(rnd_q(r_f_pry, r_f.vy[W-1]))) : r_f.vy;
        end
    end

    // gravity
    t_part r_h;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h.px   <= r_g.px;
            r_h.py   <= r_g.py;
            r_h.vx   <= r_g.vx;
            r_h.mass <= r_g.mass;
            r_h.vy   <= sat_w(SAT_W'(r_g.vy) + SAT_W'($signed({1'b0, GRAV})));
        end
    end

    // walls: compare, clamp, bounce product
    logic signed [PW-1:0] w_top, w_bot, w_lft, w_rgt, w_px, w_py;
    logic                 w_ytop, w_ybot, w_xl, w_xr;
    assign w_top  = PW'($signed({1'b0, r_top, {FRAC_BITS{1'b0}}}));
    assign w_bot  = PW'($signed({1'b0, {1'b0, r_top} + {1'b0, r_height}, {FRAC_BITS{1'b0}}}));
    assign w_lft  = PW'($signed({1'b0, r_left, {FRAC_BITS{1'b0}}}));
    assign w_rgt  = PW'($signed({1'b0, {1'b0, r_left} + {1'b0, r_width}, {FRAC_BITS{1'b0}}}));
    assign w_px   = PW'(r_h.px);
    assign w_py   = PW'(r_h.py);
    assign w_ytop = w_py < w_top;
    assign w_ybot = w_py > w_bot;
    assign w_xl   = w_px < w_lft;
    assign w_xr   = w_px > w_rgt;

    logic signed [PW-1:0] r_r_px, r_r_py;
    logic signed [W-1:0]  r_r_vx, r_r_vy;
    logic [MW-1:0]        r_r_mass;
    logic [PRW-1:0]       r_r_prx, r_r_pry;
    logic                 r_r_rfx, r_r_rfy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r_px   <= w_xl ? w_lft : (w_xr ? w_rgt : w_px);
            r_r_py   <= w_ytop ? w_top : (w_ybot ? w_bot : w_py);
            r_r_vx   <= r_h.vx;
            r_r_vy   <= r_h.vy;
            r_r_mass <= r_h.mass;
            r_r_rfx  <= w_xl || w_xr;
            r_r_rfy  <= w_ytop || w_ybot;
            r_r_prx  <= PRW'(abs_w(r_h.vx)) * PRW'(BOUNCE_K);
            r_r_pry  <= PRW'(abs_w(r_h.vy)) * PRW'(w_ytop ? BOUNCE_K : BOUNCE_B_K);
        end
    end

    // bounce round, negate, select
    logic signed [PW-1:0] r_s_px, r_s_py;
    logic signed [W-1:0]  r_s_vx, r_s_vy;
    logic [MW-1:0]        r_s_mass;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_px   <= r_r_px;
            r_s_py   <= r_r_py;
            r_s_mass <= r_r_mass;
            r_s_vx   <= r_r_rfx ? sat_w(SAT_W'(rnd_q(r_r_prx, !r_r_vx[W-1]))) : r_r_vx;
            r_s_vy   <= r_r_rfy ? sat_w(SAT_W'(rnd_q(r_r_pry, !r_r_vy[W-1]))) : r_r_vy;
        end
    end

    // velocity over mass divider, one quotient bit per stage
    t_mdiv w_md0;
    always_comb begin
        w_md0.nx = {abs_w(r_s_vx), {MFB{1'b0}}};
        w_md0.ny = {abs_w(r_s_vy), {MFB{1'b0}}};
        w_md0.rx = '0;
        w_md0.ry = '0;
        w_md0.m  = (r_s_mass == '0) ? MW'(1) : r_s_mass;
        w_md0.px = r_s_px;
        w_md0.py = r_s_py;
        w_md0.vx = r_s_vx;
        w_md0.vy = r_s_vy;
    end

    t_mdiv r_md [MNW];
    for (genvar j = 0; j < MNW; j++) begin : g_mdiv
        t_mdiv       in_s, n_s;
        logic [MW:0] tx, ty;
        if (j == 0) begin : g_first
            assign in_s = w_md0;
        end else begin : g_next
            assign in_s = r_md[j-1];
        end
        always_comb begin
            n_s = in_s;
            tx  = {in_s.rx, in_s.nx[MNW-1]};
            ty  = {in_s.ry, in_s.ny[MNW-1]};
            if (tx >= {1'b0, in_s.m}) begin
                n_s.rx = MW'(tx - {1'b0, in_s.m});
                n_s.nx = {in_s.nx[MNW-2:0], 1'b1};
            end else begin
                n_s.rx = MW'(tx);
                n_s.nx = {in_s.nx[MNW-2:0], 1'b0};
            end
            if (ty >= {1'b0, in_s.m}) begin
                n_s.ry = MW'(ty - {1'b0, in_s.m});
                n_s.ny = {in_s.ny[MNW-2:0], 1'b1};
            end else begin
                n_s.ry = MW'(ty);
                n_s.ny = {in_s.ny[MNW-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_md[j] <= n_s;
            end
        end
    end

    // position update and output word
    t_mdiv                  w_mf;
    logic signed [SUMW-1:0] w_mx, w_my, w_sx, w_sy;
    assign w_mf = r_md[MNW-1];
    assign w_mx = SUMW'($signed({1'b0, w_mf.nx}));
    assign w_my = SUMW'($signed({1'b0, w_mf.ny}));
    assign w_sx = SUMW'(w_mf.px) + (w_mf.vx[W-1] ? -w_mx : w_mx);
    assign w_sy = SUMW'(w_mf.py) + (w_mf.vy[W-1] ? -w_my : w_my);

    logic signed [W-1:0] r_o_px, r_o_py, r_o_vx, r_o_vy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_px <= sat_w(SAT_W'(w_sx));
            r_o_py <= sat_w(SAT_W'(w_sy));
            r_o_vx <= w_mf.vx;
            r_o_vy <= w_mf.vy;
        end
    end

    assign o_new_pos_x = r_o_px;
    assign o_new_pos_y = r_o_py;
    assign o_new_vel_x = r_o_vx;
    assign o_new_vel_y = r_o_vy;

    logic [QW+MNW+9:0] w_vld_all;
    assign w_vld_all = {r_a_vld, r_b_vld, r_c_vld, r_dv_vld, r_t_vld, r_f_vld, r_g_vld,
                        r_h_vld, r_r_vld, r_s_vld, r_md_vld, r_o_vld};

    `PP_ASSERT_NEXT(a_stall_freeze, !w_en, $stable(w_vld_all), "pipeline moved while stalled")
    `PP_ASSERT_NEXT(a_accept_enters, i_valid && o_ready, r_a_vld, "accepted word lost at entry")
    `PP_ASSERT_NEXT(a_tail_reaches_out, w_en && r_md_vld[MNW-1], o_valid, "word lost at output")

endmodule

// ===== tb/sv/particle_physics_step_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for particle_physics_step: directed table, then random particles.
// Depends on pp_pkg; predicts or looks up each result and compares it with what the core returns.
module particle_physics_step_tb
    import pp_pkg::*;
();

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_WORDS = 75;

    typedef struct {
        logic signed [W-1:0] px, py, vx, vy;
        logic [MW-1:0]       m;
    } t_in;

    typedef struct {
        logic [W-1:0] px, py, vx, vy;
    } t_out;

    typedef struct {
        t_in  pl;
        logic known;
        t_out ex;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic signed [W-1:0] i_pos_x, i_pos_y, i_vel_x, i_vel_y;
    logic [MW-1:0]       i_mass;
    logic                o_valid;
    logic                i_ready;
    logic signed [W-1:0] o_new_pos_x, o_new_pos_y, o_new_vel_x, o_new_vel_y;
    logic                i_cfg_we;
    t_reg_idx            i_cfg_idx;
    logic [CW-1:0]       i_cfg_data;

    logic [CW-1:0] c_mx, c_my, c_left, c_top, c_w, c_h;
    logic          c_att, c_fric;

    t_out   motion_q[$];
    t_row   tag_q[$];
    int     fails = 0;
    int     stall_cnt = 0;
    bit     quiet = 0;
    bit     hold_req = 0;

    particle_physics_step dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint sat24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint scale_q16(longint v, longint c);
        longint p;
        longint r;
        p = v * c;
        r = ((p < 0 ? -p : p) + 32768) >>> 16;
        return p < 0 ? -r : r;
    endfunction

    function automatic longint pull_term(longint d, longint unsigned d2);
        longint unsigned num, q, r;
        num = longint'(d < 0 ? -d : d) * 100;
        q = num / d2;
        r = num % d2;
        for (int i = 0; i < 2 * FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d2) begin
                r = r - d2;
                q = q | 1;
            end
        end
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint bounce(longint v, longint c);
        return sat24(-scale_q16(v, c));
    endfunction

    function automatic t_out advance_particle(t_in a);
        longint px, py, vx, vy, top, bot, lft, rgt, grav, dx, dy, ax, ay;
        longint unsigned d2, m, mx, my;
        t_out o;
        px = a.px; py = a.py; vx = a.vx; vy = a.vy;
        m = a.m;
        top = longint'(c_top) << FRAC_BITS;
        bot = (longint'(c_top) + longint'(c_h)) << FRAC_BITS;
        lft = longint'(c_left) << FRAC_BITS;
        rgt = (longint'(c_left) + longint'(c_w)) << FRAC_BITS;
        grav = ((5 << FRAC_BITS) + 50) / 100;
        if (c_att) begin
            dx = (longint'(c_mx) << FRAC_BITS) - px;
            dy = (longint'(c_my) << FRAC_BITS) - py;
            d2 = dx * dx + dy * dy;
            if (d2 > (longint'(4) << (2 * FRAC_BITS))) begin
                ax = pull_term(dx, d2);
                ay = pull_term(dy, d2);
                vx = sat24(vx + ax);
                vy = sat24(vy + ay);
            end
        end
        if (c_fric) begin
            vx = sat24(scale_q16(vx, 65470));
            vy = sat24(scale_q16(vy, 65470));
        end
        vy = sat24(vy + grav);
        if (py < top) begin vy = bounce(vy, 58982); py = top; end
        if (py > bot) begin vy = bounce(vy, 29491); py = bot; end
        if (px < lft) begin vx = bounce(vx, 58982); px = lft; end
        if (px > rgt) begin vx = bounce(vx, 58982); px = rgt; end
        if (m == 0) m = 1;
        mx = longint'(vx < 0 ? -vx : vx) * 32768 / m;
        my = longint'(vy < 0 ? -vy : vy) * 32768 / m;
        px = sat24(px + (vx < 0 ? -longint'(mx) : longint'(mx)));
        py = sat24(py + (vy < 0 ? -longint'(my) : longint'(my)));
        o.px = px[W-1:0]; o.py = py[W-1:0]; o.vx = vx[W-1:0]; o.vy = vy[W-1:0];
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_in  a;
        t_row tg;
        t_out e;
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_idx)
                REG_MOUSE_X:  c_mx   = i_cfg_data;
                REG_MOUSE_Y:  c_my   = i_cfg_data;
                REG_ATTRACT:  c_att  = i_cfg_data[0];
                REG_FRICTION: c_fric = i_cfg_data[0];
                REG_LEFT:     c_left = i_cfg_data;
                REG_TOP:      c_top  = i_cfg_data;
                REG_WIDTH:    c_w    = i_cfg_data;
                REG_HEIGHT:   c_h    = i_cfg_data;
                default: ;
            endcase
        end
        if (i_rst_n && i_valid && o_ready) begin
            a.px = i_pos_x; a.py = i_pos_y; a.vx = i_vel_x; a.vy = i_vel_y; a.m = i_mass;
            tg = tag_q.pop_front();
            motion_q.push_back(tg.known ? tg.ex : advance_particle(a));
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (motion_q.size() == 0) begin
                $display("%0t: unexpected word %h %h %h %h", $time,
                         o_new_pos_x, o_new_pos_y, o_new_vel_x, o_new_vel_y);
                fails++;
            end else begin
                e = motion_q.pop_front();
                if (o_new_pos_x !== e.px || o_new_pos_y !== e.py ||
                    o_new_vel_x !== e.vx || o_new_vel_y !== e.vy) begin
                    $display("%0t: expected %h %h %h %h got %h %h %h %h", $time,
                             e.px, e.py, e.vx, e.vy,
                             o_new_pos_x, o_new_pos_y, o_new_vel_x, o_new_vel_y);
                    fails++;
                end
            end
        end
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // output side: random back-pressure, plus one long hold-off on request
    initial begin
        i_ready <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
    end

    task automatic put_word(t_in pl, logic known, t_out ex);
        t_row tg;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        tg.pl = pl; tg.known = known; tg.ex = ex;
        tag_q.push_back(tg);
        i_valid <= 1'b1;
        i_pos_x <= pl.px; i_pos_y <= pl.py; i_vel_x <= pl.vx; i_vel_y <= pl.vy;
        i_mass  <= pl.m;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        wait (motion_q.size() == 0);
        @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic set_regs(int mx, int my, int att, int fr, int l, int t, int w, int h);
        logic [CW-1:0] v[8];
        v = '{CW'(mx), CW'(my), CW'(att), CW'(fr), CW'(l), CW'(t), CW'(w), CW'(h)};
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_reg_idx'(i);
            i_cfg_data <= v[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in mk(longint px, longint py, longint vx, longint vy, longint m);
        t_in a;
        a.px = W'(px); a.py = W'(py); a.vx = W'(vx); a.vy = W'(vy); a.m = MW'(m);
        return a;
    endfunction

    function automatic logic signed [W-1:0] edge_val();
        case ($urandom_range(0, 3))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic t_in rand_particle();
        t_in a;
        int  sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            a.px = W'((longint'(c_left) << FRAC_BITS) - (20 << FRAC_BITS)
                   + longint'($urandom_range(0, (int'(c_w) + 40) << FRAC_BITS)));
            a.py = W'((longint'(c_top) << FRAC_BITS) - (20 << FRAC_BITS)
                   + longint'($urandom_range(0, (int'(c_h) + 40) << FRAC_BITS)));
            a.vx = W'(int'($urandom_range(0, 40000)) - 20000);
            a.vy = W'(int'($urandom_range(0, 40000)) - 20000);
            a.m  = MW'($urandom_range(32768, 65536));
        end else if (sel <= 7) begin
            a.px = W'((longint'(c_mx) << FRAC_BITS) + int'($urandom_range(0, 8192)) - 4096);
            a.py = W'((longint'(c_my) << FRAC_BITS) + int'($urandom_range(0, 8192)) - 4096);
            a.vx = W'(int'($urandom_range(0, 4000)) - 2000);
            a.vy = W'(int'($urandom_range(0, 4000)) - 2000);
            a.m  = MW'($urandom_range(32768, 65536));
        end else if (sel == 8) begin
            a.px = W'($urandom); a.py = W'($urandom); a.vx = W'($urandom);
            a.vy = W'($urandom);
            a.m  = MW'($urandom);
        end else begin
            a.px = edge_val(); a.py = edge_val(); a.vx = edge_val(); a.vy = edge_val();
            a.m  = $urandom_range(0, 1) ? MW'(0) : MW'($urandom);
        end
        return a;
    endfunction

    initial begin
        t_row rows[$];
        t_row r;
        t_out none;
        int   att_row;
        none = '{default: '0};
        i_rst_n <= 1'b0; i_valid <= 1'b0; i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_MOUSE_X; i_cfg_data <= '0;
        i_pos_x <= '0; i_pos_y <= '0; i_vel_x <= '0; i_vel_y <= '0; i_mass <= '0;
        c_mx = 0; c_my = 0; c_att = 0; c_fric = 1;
        c_left = 0; c_top = 0; c_w = 1920; c_h = 1080;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 0..1920 by 0..1080, friction on
        rows.push_back('{mk(0, 0, 0, 0, 32768), 1, '{0, 51, 0, 51}});
        rows.push_back('{mk(0, 0, 0, 0, 0), 1, '{0, 1671168, 0, 51}});
        rows.push_back('{mk(8388607, 8388607, 8388607, 8388607, 65536), 0, none});
        rows.push_back('{mk(-8388608, -8388608, -8388608, -8388608, 32768), 0, none});
        rows.push_back('{mk(960 << 10, 540 << 10, 0, 0, 1), 0, none});
        rows.push_back('{mk(100 << 10, 100 << 10, 8388607, 8388607, 1), 0, none});
        rows.push_back('{mk(100 << 10, 100 << 10, -8388608, -8388608, 1), 0, none});
        rows.push_back('{mk(500 << 10, 500 << 10, 3000, -3000, 131071), 0, none});
        rows.push_back('{mk(300 << 10, -1024, 500, -2048, 40000), 0, none});
        rows.push_back('{mk(300 << 10, 1100 << 10, 500, 3000, 50000), 0, none});
        rows.push_back('{mk(-5000, 300 << 10, -700, 10, 60000), 0, none});
        rows.push_back('{mk(2000 << 10, 300 << 10, 900, 10, 32768), 0, none});
        rows.push_back('{mk(0, 0, -100, -100, 32768), 0, none});
        rows.push_back('{mk(1920 << 10, 1080 << 10, 100, 100, 32768), 0, none});
        rows.push_back('{mk('h555555, 'h2AAAAA, 'h555555, 'hAAAAAA, 'h15555), 0, none});
        rows.push_back('{mk('hAAAAAA, 'hD55555, 'hAAAAAA, 'h555555, 'h0AAAA), 0, none});
        att_row = rows.size();
        // attraction to (100,100): on the point, inside, on and beyond the 2 pixel ring
        rows.push_back('{mk(100 << 10, 100 << 10, 0, 0, 32768), 0, none});
        rows.push_back('{mk(101 << 10, 100 << 10, 0, 0, 32768), 0, none});
        rows.push_back('{mk(102 << 10, 100 << 10, 0, 0, 32768), 0, none});
        rows.push_back('{mk(100 << 10, 103 << 10, 0, 0, 32768), 0, none});
        rows.push_back('{mk(0, 0, 10, 10, 32768), 0, none});
        rows.push_back('{mk(1900 << 10, 1000 << 10, -10, 10, 65536), 0, none});

        foreach (rows[i]) begin
            if (i == att_row) begin
                wait_idle();
                set_regs(100, 100, 1, 0, 0, 0, 1920, 1080);
            end
            r = rows[i];
            put_word(r.pl, r.known, r.ex);
        end

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: set_regs(960, 540, 1, 1, 0, 0, 1920, 1080);
                1: set_regs(0, 0, 0, 0, 0, 0, 1, 1);
                2: set_regs(4095, 4095, 1, 0, 4095, 4095, 4095, 4095);
                3: set_regs($urandom, $urandom, 1, 1, $urandom_range(0, 500),
                            $urandom_range(0, 500), $urandom_range(1, 2000),
                            $urandom_range(1, 2000));
                4: set_regs($urandom_range(0, 200), $urandom_range(0, 200), 1, 1,
                            100, 50, 0, 0);
                default: set_regs($urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom);
            endcase
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (ph == 0 && k == 5) hold_req = 1;
                if (ph == 5 && k == PHASE_WORDS - 25) quiet = 1;
                put_word(rand_particle(), 1'b0, none);
            end
        end

        i_valid <= 1'b0;
        quiet = 1;
        wait (motion_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (fails == 0 && motion_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pp_pkg.sv
rtl/core/particle_physics_step.sv
tb/sv/particle_physics_step_tb.sv
